// ----- sv/gbci_pkg.sv -----
// Shared constants and an elaboration-time log function for the gated beam charge integrator.
package gbci_pkg;

    localparam int CURRENT_W = 16;
    localparam int TIME_W = 32;
    localparam int CORR_W = 17;
    localparam int CHARGE_W = 56;
    localparam int TOTAL_W = 40;
    localparam int FACTOR_W = 17;
    localparam int THRESH_W = 16;
    localparam int DQ_W = 42;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_THRESHOLD = 2'd0;

    localparam int FACTOR_TABLE_DEPTH_DEFAULT = 1024;

    localparam int LOW_EDGE = 512;
    localparam int HIGH_EDGE = 15360;
    localparam int LOW_SPAN = 14848;
    localparam int SPAN_W = 14;

    localparam int SLOPE_DIVISOR = 1250;
    localparam int SLOPE_SHIFT = 7;
    localparam int SLOPE_BIAS = 625;
    localparam int SLOPE_QUO_W = 13;

    localparam int ONE_Q16 = 65536;
    localparam int LOG_FRAC = 24;

    // Integer log2 with LOG_FRAC fraction bits by repeated squaring, truncated.
    function automatic logic [63:0] fixed_log2(input logic [31:0] c);
        int unsigned n;
        logic [63:0] y;
        logic [63:0] r;
        n = 0;
        while (n < 31 && (c >> (n + 1)) != 32'd0) begin
            n++;
        end
        y = 64'(c) << (31 - n);
        r = 64'(n) << LOG_FRAC;
        for (int i = LOG_FRAC - 1; i >= 0; i--) begin
            y = (y * y) >> 31;
            if (y >= 64'h1_0000_0000) begin
                y = y >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    localparam logic [63:0] LOG_TOP = fixed_log2(32'(HIGH_EDGE));
    localparam logic [63:0] LOG_SPAN = LOG_TOP - fixed_log2(32'(LOW_EDGE));

endpackage

// ----- sv/gated_beam_charge_integrator_unit.sv -----
// Gated beam charge integrator: current correction, beam cut and saturating charge and time totals.
//
// Each scaler read (beam current in Q8.8 uA and a cumulative 1 MHz tick count) is corrected by
// a factor of one up to 2 uA, a log-shaped table entry between 2 and 60 uA and a linear rise
// above 60 uA, then compared with the threshold register. A read that passes adds corrected current
// times elapsed ticks to the charge total and the ticks to the time total; both totals stop at
// all ones. The work is bit-serial: a restoring divider finds the table index or the slope term
// one quotient bit per cycle, with a quotient of max(13, clog2(FACTOR_TABLE_DEPTH)) bits; the table
// is a ROM with one registered read, and the correction and charge products are shift-and-add
// multiplies. The divider and table read run only above 2 uA (table or slope range); the charge
// product and the accumulation run only when the interval counts. A new request is taken while
// the previous result still waits on result_stall.
module gated_beam_charge_integrator_unit #(
    parameter int FACTOR_TABLE_DEPTH = gbci_pkg::FACTOR_TABLE_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gbci_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gbci_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gbci_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                read_valid,
    output logic                                read_stall,
    input  logic [gbci_pkg::CURRENT_W-1:0]      beam_current,
    input  logic [gbci_pkg::TIME_W-1:0]         time_count,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [gbci_pkg::CORR_W-1:0]         corrected_current,
    output logic                                interval_counted,
    output logic [gbci_pkg::CHARGE_W-1:0]       charge_total,
    output logic [gbci_pkg::TOTAL_W-1:0]        time_total
);
    import gbci_pkg::*;

    localparam int IDX_W = $clog2(FACTOR_TABLE_DEPTH);
    localparam int QUO_W = (IDX_W > SLOPE_QUO_W) ? IDX_W : SLOPE_QUO_W;
    localparam int NUM_W = SPAN_W + QUO_W;
    localparam int MUL1_STEPS = CURRENT_W;
    localparam int MUL2_STEPS = CORR_W;
    localparam int STEP_MAX = (QUO_W > MUL2_STEPS) ? QUO_W : MUL2_STEPS;
    localparam int STEP_W = $clog2(STEP_MAX);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_ROM   = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_MUL1  = 4'd4;
    localparam logic [3:0] S_CORR  = 4'd5;
    localparam logic [3:0] S_MUL2  = 4'd6;
    localparam logic [3:0] S_ROUND = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam logic [1:0] RANGE_UNITY = 2'd0;
    localparam logic [1:0] RANGE_TABLE = 2'd1;
    localparam logic [1:0] RANGE_SLOPE = 2'd2;

    logic [FACTOR_W-1:0] factor_rom [FACTOR_TABLE_DEPTH];

    // Table entry k holds the factor at the midpoint code of its slice of (2, 60] uA.
    for (genvar k = 0; k < FACTOR_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] CODE_RAW = 64'(LOW_EDGE + 1)
            + ((64'(2 * k + 1)) * 64'(LOW_SPAN)) / (64'(2) * 64'(FACTOR_TABLE_DEPTH));
        localparam logic [63:0] CODE = (CODE_RAW > 64'(HIGH_EDGE)) ? 64'(HIGH_EDGE) : CODE_RAW;
        localparam logic [63:0] DROP = LOG_TOP - fixed_log2(CODE[31:0]);
        localparam logic [63:0] ENTRY = 64'(ONE_Q16)
            + (64'(45) * 64'(ONE_Q16) * 64'(2) * DROP + 64'(1000) * LOG_SPAN)
            / (64'(2000) * LOG_SPAN);
        assign factor_rom[k] = FACTOR_W'(ENTRY);
    end

    logic [FACTOR_W-1:0] rom_q_reg;

    logic [3:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [1:0]            range_reg, range_next;
    logic [THRESH_W-1:0]   threshold_reg, threshold_next;
    logic [TIME_W-1:0]     prev_time_reg, prev_time_next;
    logic [TIME_W-1:0]     elapsed_reg, elapsed_next;
    logic [SPAN_W-1:0]     divisor_reg, divisor_next;
    logic [SPAN_W-1:0]     rem_reg, rem_next;
    logic [QUO_W-1:0]      quo_reg, quo_next;
    logic [FACTOR_W-1:0]   factor_reg, factor_next;
    logic [FACTOR_W-1:0]   mul_hi_reg, mul_hi_next;
    logic [CURRENT_W-1:0]  mul_lo_reg, mul_lo_next;
    logic [CORR_W-1:0]     corr_reg, corr_next;
    logic                  counted_reg, counted_next;
    logic [TIME_W-1:0]     chg_hi_reg, chg_hi_next;
    logic [CORR_W-1:0]     chg_lo_reg, chg_lo_next;
    logic [DQ_W-1:0]       dq_reg, dq_next;
    logic [CHARGE_W-1:0]   charge_acc_reg, charge_acc_next;
    logic [TOTAL_W-1:0]    time_acc_reg, time_acc_next;
    logic                  result_valid_reg, result_valid_next;
    logic [CORR_W-1:0]     corrected_current_reg, corrected_current_next;
    logic                  interval_counted_reg, interval_counted_next;
    logic [CHARGE_W-1:0]   charge_total_reg, charge_total_next;
    logic [TOTAL_W-1:0]    time_total_reg, time_total_next;

    logic [NUM_W-1:0]      num;
    logic [SPAN_W:0]       trial;
    logic                  trial_ge;
    logic [FACTOR_W:0]     sum1;
    logic [TIME_W:0]       sum2;
    logic [CHARGE_W:0]     charge_sum;
    logic [TOTAL_W:0]      time_sum;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_THRESHOLD) ? APB_DATA_W'(threshold_reg) : '0;

    assign read_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign corrected_current = corrected_current_reg;
    assign interval_counted = interval_counted_reg;
    assign charge_total = charge_total_reg;
    assign time_total = time_total_reg;

    always_ff @(posedge clk)
    begin
        rom_q_reg <= factor_rom[quo_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        if (beam_current <= CURRENT_W'(HIGH_EDGE)) begin
            num = NUM_W'(SPAN_W'(beam_current - CURRENT_W'(LOW_EDGE + 1)))
                * NUM_W'(FACTOR_TABLE_DEPTH);
        end else begin
            num = (NUM_W'(beam_current - CURRENT_W'(HIGH_EDGE)) << SLOPE_SHIFT)
                + NUM_W'(SLOPE_BIAS);
        end

        trial = {rem_reg, quo_reg[QUO_W-1]};
        trial_ge = (trial >= {1'b0, divisor_reg});
        sum1 = {1'b0, mul_hi_reg} + (mul_lo_reg[0] ? {1'b0, factor_reg} : '0);
        sum2 = {1'b0, chg_hi_reg} + (chg_lo_reg[0] ? {1'b0, elapsed_reg} : '0);
        charge_sum = {1'b0, charge_acc_reg} + (CHARGE_W + 1)'(dq_reg);
        time_sum = {1'b0, time_acc_reg} + (TOTAL_W + 1)'(elapsed_reg);

        state_next = state_reg;
        step_next = step_reg;
        range_next = range_reg;
        threshold_next = threshold_reg;
        prev_time_next = prev_time_reg;
        elapsed_next = elapsed_reg;
        divisor_next = divisor_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        factor_next = factor_reg;
        mul_hi_next = mul_hi_reg;
        mul_lo_next = mul_lo_reg;
        corr_next = corr_reg;
        counted_next = counted_reg;
        chg_hi_next = chg_hi_reg;
        chg_lo_next = chg_lo_reg;
        dq_next = dq_reg;
        charge_acc_next = charge_acc_reg;
        time_acc_next = time_acc_reg;
        result_valid_next = result_valid_reg;
        corrected_current_next = corrected_current_reg;
        interval_counted_next = interval_counted_reg;
        charge_total_next = charge_total_reg;
        time_total_next = time_total_reg;

        if (psel && penable && pwrite && paddr == ADDR_THRESHOLD) begin
            threshold_next = pwdata[THRESH_W-1:0];
        end

        if (result_valid_reg && !result_stall) begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (read_valid) begin
                    elapsed_next = time_count - prev_time_reg;
                    prev_time_next = time_count;
                    mul_lo_next = beam_current;
                    mul_hi_next = '0;
                    factor_next = FACTOR_W'(ONE_Q16);
                    rem_next = SPAN_W'(num >> QUO_W);
                    quo_next = num[QUO_W-1:0];
                    step_next = '0;
                    if (beam_current <= CURRENT_W'(LOW_EDGE)) begin
                        range_next = RANGE_UNITY;
                        state_next = S_MUL1;
                    end else if (beam_current <= CURRENT_W'(HIGH_EDGE)) begin
                        range_next = RANGE_TABLE;
                        divisor_next = SPAN_W'(LOW_SPAN);
                        state_next = S_DIV;
                    end else begin
                        range_next = RANGE_SLOPE;
                        divisor_next = SPAN_W'(SLOPE_DIVISOR);
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                quo_next = {quo_reg[QUO_W-2:0], trial_ge};
                rem_next = trial_ge ? SPAN_W'(trial - {1'b0, divisor_reg}) : trial[SPAN_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QUO_W - 1)) begin
                    state_next = S_ROM;
                end
            end
            S_ROM:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (range_reg == RANGE_TABLE) begin
                    factor_next = rom_q_reg;
                end else begin
                    factor_next = FACTOR_W'(ONE_Q16) + FACTOR_W'(quo_reg);
                end
                step_next = '0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                mul_hi_next = sum1[FACTOR_W:1];
                mul_lo_next = {sum1[0], mul_lo_reg[CURRENT_W-1:1]};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MUL1_STEPS - 1)) begin
                    state_next = S_CORR;
                end
            end
            S_CORR:
            begin
                corr_next = mul_hi_reg + FACTOR_W'(mul_lo_reg[CURRENT_W-1]);
                counted_next = (corr_next > CORR_W'(threshold_reg));
                chg_hi_next = '0;
                chg_lo_next = corr_next;
                step_next = '0;
                state_next = counted_next ? S_MUL2 : S_DONE;
            end
            S_MUL2:
            begin
                chg_hi_next = sum2[TIME_W:1];
                chg_lo_next = {sum2[0], chg_lo_reg[CORR_W-1:1]};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MUL2_STEPS - 1)) begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                dq_next = DQ_W'({chg_hi_reg, chg_lo_reg[CORR_W-1:8]}) + DQ_W'(chg_lo_reg[7]);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                charge_acc_next = charge_sum[CHARGE_W] ? '1 : charge_sum[CHARGE_W-1:0];
                time_acc_next = time_sum[TOTAL_W] ? '1 : time_sum[TOTAL_W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall) begin
                    corrected_current_next = corr_reg;
                    interval_counted_next = counted_reg;
                    charge_total_next = charge_acc_reg;
                    time_total_next = time_acc_reg;
                    result_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            range_reg <= RANGE_UNITY;
            threshold_reg <= '0;
            prev_time_reg <= '0;
            charge_acc_reg <= '0;
            time_acc_reg <= '0;
            result_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            range_reg <= range_next;
            threshold_reg <= threshold_next;
            prev_time_reg <= prev_time_next;
            charge_acc_reg <= charge_acc_next;
            time_acc_reg <= time_acc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg <= elapsed_next;
        divisor_reg <= divisor_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        factor_reg <= factor_next;
        mul_hi_reg <= mul_hi_next;
        mul_lo_reg <= mul_lo_next;
        corr_reg <= corr_next;
        counted_reg <= counted_next;
        chg_hi_reg <= chg_hi_next;
        chg_lo_reg <= chg_lo_next;
        dq_reg <= dq_next;
        corrected_current_reg <= corrected_current_next;
        interval_counted_reg <= interval_counted_next;
        charge_total_reg <= charge_total_next;
        time_total_reg <= time_total_next;
    end

endmodule
